FILE: hdl/nsbp_pkg.sv
// Shared codes, types and slice tables for the nine-slice blit planner.
package nsbp_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int NUM_SLICES         = 9;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_HOLE    = 2'd1,
      MODE_STRETCH = 2'd2,
      MODE_GRID    = 2'd3
   } draw_mode_type;

   localparam logic [1:0] KIND_COPY    = 2'd0;
   localparam logic [1:0] KIND_STRETCH = 2'd1;
   localparam logic [1:0] KIND_BLEND   = 2'd2;

   localparam logic [1:0] CSR_DRAW_MODE     = 2'd0;
   localparam logic [1:0] CSR_SOURCE_RECT   = 2'd1;
   localparam logic [1:0] CSR_CORNER_INSETS = 2'd2;
   localparam logic [1:0] CSR_HAS_ALPHA     = 2'd3;

   localparam logic [7:0] FULL_ALPHA = 8'd255;

   // Slice set and the blit kind selection for one planned draw.
   typedef struct packed {
      logic [NUM_SLICES-1:0] mask;
      logic [1:0]            kind_corner;
      logic [1:0]            kind_edge;
   } plan_ctrl_type;

   // Emission order: TL, TM, TR, LM, BL, BM, BR, RM, centre.
   function automatic logic [1:0] slice_row(input logic [3:0] idx);
      logic [1:0] r;
      case (idx)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd4, 4'd5, 4'd6: r = 2'd2;
         default:          r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] slice_col(input logic [3:0] idx);
      logic [1:0] c;
      case (idx)
         4'd0, 4'd3, 4'd4: c = 2'd0;
         4'd2, 4'd6, 4'd7: c = 2'd2;
         default:          c = 2'd1;
      endcase
      return c;
   endfunction

   function automatic logic slice_corner(input logic [3:0] idx);
      logic k;
      case (idx)
         4'd0, 4'd2, 4'd4, 4'd6: k = 1'b1;
         default:                k = 1'b0;
      endcase
      return k;
   endfunction

endpackage

FILE: hdl/nine_slice_blit_planner.sv
// Top level of the nine-slice blit planner: configuration registers and pipeline.
//
// Each request carries a destination paint rectangle and a constant alpha; the
// block answers with the blit commands that draw the configured bitmap part into
// it. Hole and stretch modes give one command, grid mode gives one command per
// present slice (one to nine, centre always last), and mode none gives no
// command at all. The last command of a request has rsp_last_piece set. Commands
// leave one per cycle from a single output register while rsp_ready is high. A
// request enters two geometry stages (spans, centering offsets, slice edges) and a
// slice sequencer; the first command passes the stage one and stage two registers,
// the sequencer's hold register and the output register. New requests can enter
// the geometry stages while the sequencer works through a grid, until both stages
// are full. Every command is an alpha blend when the texture has alpha or the
// constant alpha is below 255. Output coordinates wrap to COORD_BITS bits. Write
// the csr_ registers only while no request is in flight; csr_ready is always high.
module nine_slice_blit_planner import nsbp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [63:0]                   csr_wdata,
   // paint requests
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_paint_left,
   input  logic signed [COORD_BITS-1:0]  req_paint_top,
   input  logic signed [COORD_BITS-1:0]  req_paint_right,
   input  logic signed [COORD_BITS-1:0]  req_paint_bottom,
   input  logic [7:0]                    req_global_alpha,
   // blit commands
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_src_left,
   output logic signed [COORD_BITS-1:0]  rsp_src_top,
   output logic signed [COORD_BITS-1:0]  rsp_src_right,
   output logic signed [COORD_BITS-1:0]  rsp_src_bottom,
   output logic signed [COORD_BITS-1:0]  rsp_dst_left,
   output logic signed [COORD_BITS-1:0]  rsp_dst_top,
   output logic signed [COORD_BITS-1:0]  rsp_dst_right,
   output logic signed [COORD_BITS-1:0]  rsp_dst_bottom,
   output logic [1:0]                    rsp_blit_kind,
   output logic                          rsp_last_piece
);

   // Configuration registers
   draw_mode_type draw_mode_ff;
   logic [63:0]   source_rect_ff;
   logic [63:0]   corner_insets_ff;
   logic          has_alpha_ff;

   logic                       plan_valid, plan_ready;
   plan_ctrl_type              plan_ctrl;
   logic [3:0][COORD_BITS-1:0] plan_src_x, plan_src_y, plan_dst_x, plan_dst_y;

   assign csr_ready = 1'b1;

   // Decode the write index and update the addressed register.
   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff     <= MODE_NONE;
         source_rect_ff   <= '0;
         corner_insets_ff <= '0;
         has_alpha_ff     <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DRAW_MODE:     draw_mode_ff     <= draw_mode_type'(csr_wdata[1:0]);
            CSR_SOURCE_RECT:   source_rect_ff   <= csr_wdata;
            CSR_CORNER_INSETS: corner_insets_ff <= csr_wdata;
            CSR_HAS_ALPHA:     has_alpha_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Geometry: spans and centering in stage one and two, slice edges after.
   nsbp_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .paint_left    (req_paint_left),
      .paint_top     (req_paint_top),
      .paint_right   (req_paint_right),
      .paint_bottom  (req_paint_bottom),
      .global_alpha  (req_global_alpha),
      .draw_mode     (draw_mode_ff),
      .source_rect   (source_rect_ff),
      .corner_insets (corner_insets_ff),
      .has_alpha     (has_alpha_ff),
      .plan_valid    (plan_valid),
      .plan_ready    (plan_ready),
      .plan_ctrl     (plan_ctrl),
      .plan_src_x    (plan_src_x),
      .plan_src_y    (plan_src_y),
      .plan_dst_x    (plan_dst_x),
      .plan_dst_y    (plan_dst_y)
   );

   // Sequencer: walk the slice mask, one command per cycle while rsp_ready is high.
   nsbp_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .plan_valid     (plan_valid),
      .plan_ready     (plan_ready),
      .plan_ctrl      (plan_ctrl),
      .plan_src_x     (plan_src_x),
      .plan_src_y     (plan_src_y),
      .plan_dst_x     (plan_dst_x),
      .plan_dst_y     (plan_dst_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_src_left   (rsp_src_left),
      .rsp_src_top    (rsp_src_top),
      .rsp_src_right  (rsp_src_right),
      .rsp_src_bottom (rsp_src_bottom),
      .rsp_dst_left   (rsp_dst_left),
      .rsp_dst_top    (rsp_dst_top),
      .rsp_dst_right  (rsp_dst_right),
      .rsp_dst_bottom (rsp_dst_bottom),
      .rsp_blit_kind  (rsp_blit_kind),
      .rsp_last_piece (rsp_last_piece)
   );

   // A planned draw waiting on the sequencer must hold its slice set.
   a_plan_hold: assert property (@(posedge clock) disable iff (reset)
      plan_valid && !plan_ready |=> plan_valid && $stable(plan_ctrl))
      else $error("planned draw changed while stalled");

   // Every planned draw yields at least one command.
   a_plan_nonempty: assert property (@(posedge clock) disable iff (reset)
      plan_valid |-> plan_ctrl.mask != '0)
      else $error("planned draw with no slices");

   // Reset empties the pipeline and the output register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !plan_valid)
      else $error("valid item after reset");

endmodule

FILE: hdl/nsbp_geom.sv
// Two-stage geometry pipeline: spans, centering offsets and grid edge coordinates.
module nsbp_geom import nsbp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [COORD_BITS-1:0]        paint_left,
   input  logic [COORD_BITS-1:0]        paint_top,
   input  logic [COORD_BITS-1:0]        paint_right,
   input  logic [COORD_BITS-1:0]        paint_bottom,
   input  logic [7:0]                   global_alpha,
   input  draw_mode_type                draw_mode,
   input  logic [63:0]                  source_rect,
   input  logic [63:0]                  corner_insets,
   input  logic                         has_alpha,
   output logic                         plan_valid,
   input  logic                         plan_ready,
   output plan_ctrl_type                plan_ctrl,
   output logic [3:0][COORD_BITS-1:0]   plan_src_x,
   output logic [3:0][COORD_BITS-1:0]   plan_src_y,
   output logic [3:0][COORD_BITS-1:0]   plan_dst_x,
   output logic [3:0][COORD_BITS-1:0]   plan_dst_y
);

   localparam int EW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
   localparam int PX = EW - COORD_BITS;
   localparam int MX = EW - 16;

   typedef logic signed [EW-1:0] ext_type;

   // Stage 1 registers
   logic          s1_valid_ff, s1_valid_in;
   ext_type       s1_pl_ff, s1_pt_ff, s1_pr_ff, s1_pb_ff;
   ext_type       s1_ml_ff, s1_mt_ff, s1_mr_ff, s1_mb_ff;
   ext_type       s1_cl_ff, s1_ct_ff, s1_cr_ff, s1_cb_ff;
   ext_type       s1_pw_ff, s1_ph_ff, s1_mw_ff, s1_mh_ff;
   draw_mode_type s1_mode_ff;
   plan_ctrl_type s1_ctrl_ff, s1_ctrl_in;

   // Stage 2 registers
   logic          s2_valid_ff, s2_valid_in;
   ext_type       s2_pl_ff, s2_pt_ff, s2_pr_ff, s2_pb_ff;
   ext_type       s2_ml_ff, s2_mt_ff, s2_mr_ff, s2_mb_ff;
   ext_type       s2_cl_ff, s2_ct_ff, s2_cr_ff, s2_cb_ff;
   ext_type       s2_pw_ff, s2_ph_ff, s2_mw_ff, s2_mh_ff;
   ext_type       s2_hx_ff, s2_hy_ff, s2_hx_in, s2_hy_in;
   logic          s2_crop_x_ff, s2_crop_y_ff;
   draw_mode_type s2_mode_ff;
   plan_ctrl_type s2_ctrl_ff;

   ext_type in_pl, in_pt, in_pr, in_pb;
   ext_type in_ml, in_mt, in_mr, in_mb;
   ext_type in_cl, in_ct, in_cr, in_cb;
   ext_type in_mw, span_dx, span_dy;
   logic    blend, in_take, s1_go;
   logic [1:0] kc, ks;
   logic [NUM_SLICES-1:0] grid_mask;

   assign s1_go    = !s2_valid_ff || plan_ready;
   assign in_ready = !s1_valid_ff || s1_go;
   assign in_take  = in_valid && in_ready;

   always_comb begin
      in_pl = {{PX{paint_left[COORD_BITS-1]}}, paint_left};
      in_pt = {{PX{paint_top[COORD_BITS-1]}}, paint_top};
      in_pr = {{PX{paint_right[COORD_BITS-1]}}, paint_right};
      in_pb = {{PX{paint_bottom[COORD_BITS-1]}}, paint_bottom};
      in_ml = {{MX{source_rect[15]}}, source_rect[15:0]};
      in_mt = {{MX{source_rect[31]}}, source_rect[31:16]};
      in_mr = {{MX{source_rect[47]}}, source_rect[47:32]};
      in_mb = {{MX{source_rect[63]}}, source_rect[63:48]};
      in_cl = {{MX{corner_insets[15]}}, corner_insets[15:0]};
      in_ct = {{MX{corner_insets[31]}}, corner_insets[31:16]};
      in_cr = {{MX{corner_insets[47]}}, corner_insets[47:32]};
      in_cb = {{MX{corner_insets[63]}}, corner_insets[63:48]};
      in_mw = in_mr - in_ml;

      blend = has_alpha || (global_alpha < FULL_ALPHA);
      kc    = blend ? KIND_BLEND : KIND_COPY;
      ks    = blend ? KIND_BLEND : KIND_STRETCH;

      grid_mask[0] = (in_cl > 0) && (in_ct > 0);
      grid_mask[1] = (in_ct > 0) && ((in_mw - in_cl - in_cr) > 0);
      grid_mask[2] = (in_ct > 0) && (in_cr > 0);
      grid_mask[3] = (in_cl > 0);
      grid_mask[4] = (in_cb > 0) && (in_cl > 0);
      grid_mask[5] = (in_cb > 0);
      grid_mask[6] = (in_cr > 0) && (in_cb > 0);
      grid_mask[7] = (in_cr > 0);
      grid_mask[8] = 1'b1;

      s1_ctrl_in.kind_edge = ks;
      unique case (draw_mode)
         MODE_GRID: begin
            s1_ctrl_in.mask        = grid_mask;
            s1_ctrl_in.kind_corner = kc;
         end
         MODE_STRETCH: begin
            s1_ctrl_in.mask        = NUM_SLICES'(1);
            s1_ctrl_in.kind_corner = ks;
         end
         default: begin
            s1_ctrl_in.mask        = NUM_SLICES'(1);
            s1_ctrl_in.kind_corner = kc;
         end
      endcase
   end

   // A draw with mode none yields no command: drop it at entry.
   always_comb begin
      if (in_take) begin
         s1_valid_in = (draw_mode != MODE_NONE);
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s2_valid_in = s1_go ? s1_valid_ff : s2_valid_ff;
   end

   // Halve the span difference, truncating toward zero.
   always_comb begin
      span_dx  = s1_mw_ff - s1_pw_ff;
      span_dy  = s1_mh_ff - s1_ph_ff;
      s2_hx_in = $signed(span_dx + EW'(span_dx[EW-1])) >>> 1;
      s2_hy_in = $signed(span_dy + EW'(span_dy[EW-1])) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_pl_ff   <= in_pl;
         s1_pt_ff   <= in_pt;
         s1_pr_ff   <= in_pr;
         s1_pb_ff   <= in_pb;
         s1_ml_ff   <= in_ml;
         s1_mt_ff   <= in_mt;
         s1_mr_ff   <= in_mr;
         s1_mb_ff   <= in_mb;
         s1_cl_ff   <= in_cl;
         s1_ct_ff   <= in_ct;
         s1_cr_ff   <= in_cr;
         s1_cb_ff   <= in_cb;
         s1_pw_ff   <= in_pr - in_pl;
         s1_ph_ff   <= in_pb - in_pt;
         s1_mw_ff   <= in_mw;
         s1_mh_ff   <= in_mb - in_mt;
         s1_mode_ff <= draw_mode;
         s1_ctrl_ff <= s1_ctrl_in;
      end
      if (s1_go && s1_valid_ff) begin
         s2_pl_ff     <= s1_pl_ff;
         s2_pt_ff     <= s1_pt_ff;
         s2_pr_ff     <= s1_pr_ff;
         s2_pb_ff     <= s1_pb_ff;
         s2_ml_ff     <= s1_ml_ff;
         s2_mt_ff     <= s1_mt_ff;
         s2_mr_ff     <= s1_mr_ff;
         s2_mb_ff     <= s1_mb_ff;
         s2_cl_ff     <= s1_cl_ff;
         s2_ct_ff     <= s1_ct_ff;
         s2_cr_ff     <= s1_cr_ff;
         s2_cb_ff     <= s1_cb_ff;
         s2_pw_ff     <= s1_pw_ff;
         s2_ph_ff     <= s1_ph_ff;
         s2_mw_ff     <= s1_mw_ff;
         s2_mh_ff     <= s1_mh_ff;
         s2_hx_ff     <= s2_hx_in;
         s2_hy_ff     <= s2_hy_in;
         s2_crop_x_ff <= !span_dx[EW-1];
         s2_crop_y_ff <= !span_dy[EW-1];
         s2_mode_ff   <= s1_mode_ff;
         s2_ctrl_ff   <= s1_ctrl_ff;
      end
   end

   // Edge coordinates of the draw; slices pick neighboring pairs.
   ext_type sx [4];
   ext_type sy [4];
   ext_type dx [4];
   ext_type dy [4];

   always_comb begin
      sx[0] = s2_ml_ff;
      sx[1] = s2_ml_ff + s2_cl_ff;
      sx[2] = s2_mr_ff - s2_cr_ff;
      sx[3] = s2_mr_ff;
      sy[0] = s2_mt_ff;
      sy[1] = s2_mt_ff + s2_ct_ff;
      sy[2] = s2_mb_ff - s2_cb_ff;
      sy[3] = s2_mb_ff;
      dx[0] = s2_pl_ff;
      dx[1] = s2_pl_ff + s2_cl_ff;
      dx[2] = s2_pr_ff - s2_cr_ff;
      dx[3] = s2_pr_ff;
      dy[0] = s2_pt_ff;
      dy[1] = s2_pt_ff + s2_ct_ff;
      dy[2] = s2_pb_ff - s2_cb_ff;
      dy[3] = s2_pb_ff;

      unique case (s2_mode_ff)
         MODE_HOLE: begin
            if (s2_crop_x_ff) begin
               sx[0] = s2_ml_ff + s2_hx_ff;
               sx[1] = s2_ml_ff + s2_hx_ff + s2_pw_ff;
               dx[1] = s2_pr_ff;
            end else begin
               sx[1] = s2_mr_ff;
               dx[0] = s2_pl_ff - s2_hx_ff;
               dx[1] = s2_pl_ff - s2_hx_ff + s2_mw_ff;
            end
            if (s2_crop_y_ff) begin
               sy[0] = s2_mt_ff + s2_hy_ff;
               sy[1] = s2_mt_ff + s2_hy_ff + s2_ph_ff;
               dy[1] = s2_pb_ff;
            end else begin
               sy[1] = s2_mb_ff;
               dy[0] = s2_pt_ff - s2_hy_ff;
               dy[1] = s2_pt_ff - s2_hy_ff + s2_mh_ff;
            end
         end
         MODE_STRETCH: begin
            sx[1] = s2_mr_ff;
            sy[1] = s2_mb_ff;
            dx[1] = s2_pr_ff;
            dy[1] = s2_pb_ff;
         end
         default: begin
         end
      endcase

      for (int i = 0; i < 4; i++) begin
         plan_src_x[i] = sx[i][COORD_BITS-1:0];
         plan_src_y[i] = sy[i][COORD_BITS-1:0];
         plan_dst_x[i] = dx[i][COORD_BITS-1:0];
         plan_dst_y[i] = dy[i][COORD_BITS-1:0];
      end
   end

   assign plan_valid = s2_valid_ff;
   assign plan_ctrl  = s2_ctrl_ff;

endmodule

FILE: hdl/nsbp_emit.sv
// Slice sequencer: holds one planned draw, issues one blit command per unstalled cycle.
module nsbp_emit import nsbp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         plan_valid,
   output logic                         plan_ready,
   input  plan_ctrl_type                plan_ctrl,
   input  logic [3:0][COORD_BITS-1:0]   plan_src_x,
   input  logic [3:0][COORD_BITS-1:0]   plan_src_y,
   input  logic [3:0][COORD_BITS-1:0]   plan_dst_x,
   input  logic [3:0][COORD_BITS-1:0]   plan_dst_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COORD_BITS-1:0]        rsp_src_left,
   output logic [COORD_BITS-1:0]        rsp_src_top,
   output logic [COORD_BITS-1:0]        rsp_src_right,
   output logic [COORD_BITS-1:0]        rsp_src_bottom,
   output logic [COORD_BITS-1:0]        rsp_dst_left,
   output logic [COORD_BITS-1:0]        rsp_dst_top,
   output logic [COORD_BITS-1:0]        rsp_dst_right,
   output logic [COORD_BITS-1:0]        rsp_dst_bottom,
   output logic [1:0]                   rsp_blit_kind,
   output logic                         rsp_last_piece
);

   logic                       hold_valid_ff, hold_valid_in;
   logic [NUM_SLICES-1:0]      rem_ff, rem_in;
   logic [3:0][COORD_BITS-1:0] sx_ff, sy_ff, dx_ff, dy_ff;
   logic [1:0]                 kind_corner_ff, kind_edge_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]      src_l_ff, src_t_ff, src_r_ff, src_b_ff;
   logic [COORD_BITS-1:0]      dst_l_ff, dst_t_ff, dst_r_ff, dst_b_ff;
   logic [1:0]                 kind_ff;
   logic                       last_ff;

   logic [3:0]            idx;
   logic [NUM_SLICES-1:0] onehot, rest;
   logic [1:0]            row, col, row_nx, col_nx;
   logic                  out_free, issue, last, load;

   // Lowest remaining slice goes next.
   always_comb begin
      idx = 4'd0;
      for (int i = NUM_SLICES - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            idx = 4'(i);
         end
      end
      onehot = NUM_SLICES'(1) << idx;
      rest   = rem_ff & ~onehot;
      last   = (rest == '0);
      row    = slice_row(idx);
      col    = slice_col(idx);
      row_nx = row + 2'd1;
      col_nx = col + 2'd1;
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign issue      = hold_valid_ff && out_free;
   assign plan_ready = !hold_valid_ff || (issue && last);
   assign load       = plan_valid && plan_ready;

   always_comb begin
      if (load) begin
         hold_valid_in = 1'b1;
         rem_in        = plan_ctrl.mask;
      end else if (issue) begin
         hold_valid_in = !last;
         rem_in        = rest;
      end else begin
         hold_valid_in = hold_valid_ff;
         rem_in        = rem_ff;
      end
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rem_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rem_ff        <= rem_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sx_ff          <= plan_src_x;
         sy_ff          <= plan_src_y;
         dx_ff          <= plan_dst_x;
         dy_ff          <= plan_dst_y;
         kind_corner_ff <= plan_ctrl.kind_corner;
         kind_edge_ff   <= plan_ctrl.kind_edge;
      end
      if (issue) begin
         src_l_ff <= sx_ff[col];
         src_r_ff <= sx_ff[col_nx];
         src_t_ff <= sy_ff[row];
         src_b_ff <= sy_ff[row_nx];
         dst_l_ff <= dx_ff[col];
         dst_r_ff <= dx_ff[col_nx];
         dst_t_ff <= dy_ff[row];
         dst_b_ff <= dy_ff[row_nx];
         kind_ff  <= slice_corner(idx) ? kind_corner_ff : kind_edge_ff;
         last_ff  <= last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_src_left   = src_l_ff;
   assign rsp_src_top    = src_t_ff;
   assign rsp_src_right  = src_r_ff;
   assign rsp_src_bottom = src_b_ff;
   assign rsp_dst_left   = dst_l_ff;
   assign rsp_dst_top    = dst_t_ff;
   assign rsp_dst_right  = dst_r_ff;
   assign rsp_dst_bottom = dst_b_ff;
   assign rsp_blit_kind  = kind_ff;
   assign rsp_last_piece = last_ff;

endmodule

FILE: test/nine_slice_blit_planner_tb.sv
// Testbench for nine_slice_blit_planner: directed and random paint items checked against a predictor.
module nine_slice_blit_planner_tb;
   import nsbp_pkg::*;

   localparam int     CW              = 16;
   localparam int     HALF_PERIOD     = 5;
   localparam int     RESET_CYCLES    = 10;
   // Extra wait after the last owed command, so the pipe is empty before the
   // registers are written again.
   localparam int     DRAIN_CYCLES    = 32;
   localparam int     IDLE_PERCENT    = 9;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam longint TIMEOUT_TIME    = 3000000;

   // One blit command as it leaves the block.
   typedef struct {
      logic signed [CW-1:0] src_left, src_top, src_right, src_bottom;
      logic signed [CW-1:0] dst_left, dst_top, dst_right, dst_bottom;
      logic [1:0]           kind;
      logic                 last_piece;
   } blit_cmd_type;

   // Rectangle with exact, unwrapped coordinates.
   typedef struct {
      longint l, t, r, b;
   } span_box_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [1:0]           csr_index;
   logic [63:0]          csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [CW-1:0] req_paint_left, req_paint_top, req_paint_right, req_paint_bottom;
   logic [7:0]           req_global_alpha;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [CW-1:0] rsp_src_left, rsp_src_top, rsp_src_right, rsp_src_bottom;
   logic signed [CW-1:0] rsp_dst_left, rsp_dst_top, rsp_dst_right, rsp_dst_bottom;
   logic [1:0]           rsp_blit_kind;
   logic                 rsp_last_piece;

   // Shadow copy of the block's registers, updated on each accepted write.
   draw_mode_type mode_q;
   logic [63:0]   source_q;
   logic [63:0]   insets_q;
   logic          alpha_q;

   // Commands still owed by the block, oldest first.
   blit_cmd_type expected_cmds[$];
   int unsigned  errors;
   event         hold_off_go;   // start one receiver hold-off
   bit           holding;       // receiver hold-off in progress
   bit           steady;        // suppress random idling on both sides

   nine_slice_blit_planner #(.COORD_BITS(CW)) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_paint_left  (req_paint_left),
      .req_paint_top   (req_paint_top),
      .req_paint_right (req_paint_right),
      .req_paint_bottom(req_paint_bottom),
      .req_global_alpha(req_global_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_src_left    (rsp_src_left),
      .rsp_src_top     (rsp_src_top),
      .rsp_src_right   (rsp_src_right),
      .rsp_src_bottom  (rsp_src_bottom),
      .rsp_dst_left    (rsp_dst_left),
      .rsp_dst_top     (rsp_dst_top),
      .rsp_dst_right   (rsp_dst_right),
      .rsp_dst_bottom  (rsp_dst_bottom),
      .rsp_blit_kind   (rsp_blit_kind),
      .rsp_last_piece  (rsp_last_piece)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Unpack left, top, right, bottom, 16 signed bits each, low field first.
   function automatic span_box_type rect_of(input logic [63:0] w);
      span_box_type q;
      q.l = longint'($signed(w[15:0]));
      q.t = longint'($signed(w[31:16]));
      q.r = longint'($signed(w[47:32]));
      q.b = longint'($signed(w[63:48]));
      return q;
   endfunction

   function automatic logic [63:0] pack_rect(input int l, input int t, input int r,
                                              input int b);
      return {16'(b), 16'(r), 16'(t), 16'(l)};
   endfunction

   // Wrap exact coordinates to the port width and queue the command.
   function automatic void queue_blit(input longint sl, input longint st, input longint sr,
                                      input longint sb, input longint dl, input longint dt,
                                      input longint dr, input longint db,
                                      input logic [1:0] kind);
      blit_cmd_type cmd;
      cmd.src_left   = CW'(sl);
      cmd.src_top    = CW'(st);
      cmd.src_right  = CW'(sr);
      cmd.src_bottom = CW'(sb);
      cmd.dst_left   = CW'(dl);
      cmd.dst_top    = CW'(dt);
      cmd.dst_right  = CW'(dr);
      cmd.dst_bottom = CW'(db);
      cmd.kind       = kind;
      cmd.last_piece = 1'b0;
      expected_cmds.push_back(cmd);
   endfunction

   // Work out the blit commands for one paint item under the current registers.
   function automatic void plan_blits(input logic signed [CW-1:0] pl,
                                      input logic signed [CW-1:0] pt,
                                      input logic signed [CW-1:0] pr,
                                      input logic signed [CW-1:0] pb,
                                      input logic [7:0] ga);
      span_box_type p, m, c;
      longint    pw, ph, mw, mh, sl, st, sr, sb, dl, dt, dr, db;
      logic      blend;
      logic [1:0] kc, ks;
      int        first;
      blit_cmd_type tail;
      p.l = pl;
      p.t = pt;
      p.r = pr;
      p.b = pb;
      m = rect_of(source_q);
      c = rect_of(insets_q);
      blend = alpha_q || (ga < FULL_ALPHA);
      kc = blend ? KIND_BLEND : KIND_COPY;
      ks = blend ? KIND_BLEND : KIND_STRETCH;
      first = expected_cmds.size();
      case (mode_q)
         MODE_HOLE: begin
            pw = p.r - p.l;
            ph = p.b - p.t;
            mw = m.r - m.l;
            mh = m.b - m.t;
            // Crop the part when it covers the paint span, else center it.
            if (mw >= pw) begin
               sl = m.l + (mw - pw) / 2;
               sr = sl + pw;
               dl = p.l;
               dr = p.r;
            end else begin
               sl = m.l;
               sr = m.r;
               dl = p.l + (pw - mw) / 2;
               dr = dl + mw;
            end
            if (mh >= ph) begin
               st = m.t + (mh - ph) / 2;
               sb = st + ph;
               dt = p.t;
               db = p.b;
            end else begin
               st = m.t;
               sb = m.b;
               dt = p.t + (ph - mh) / 2;
               db = dt + mh;
            end
            queue_blit(sl, st, sr, sb, dl, dt, dr, db, kc);
         end
         MODE_STRETCH: begin
            queue_blit(m.l, m.t, m.r, m.b, p.l, p.t, p.r, p.b, ks);
         end
         MODE_GRID: begin
            if (c.l > 0 && c.t > 0)
               queue_blit(m.l, m.t, m.l + c.l, m.t + c.t,
                          p.l, p.t, p.l + c.l, p.t + c.t, kc);
            if (c.t > 0 && (m.r - m.l) - c.l - c.r > 0)
               queue_blit(m.l + c.l, m.t, m.r - c.r, m.t + c.t,
                          p.l + c.l, p.t, p.r - c.r, p.t + c.t, ks);
            if (c.t > 0 && c.r > 0)
               queue_blit(m.r - c.r, m.t, m.r, m.t + c.t,
                          p.r - c.r, p.t, p.r, p.t + c.t, kc);
            if (c.l > 0)
               queue_blit(m.l, m.t + c.t, m.l + c.l, m.b - c.b,
                          p.l, p.t + c.t, p.l + c.l, p.b - c.b, ks);
            if (c.b > 0 && c.l > 0)
               queue_blit(m.l, m.b - c.b, m.l + c.l, m.b,
                          p.l, p.b - c.b, p.l + c.l, p.b, kc);
            if (c.b > 0)
               queue_blit(m.l + c.l, m.b - c.b, m.r - c.r, m.b,
                          p.l + c.l, p.b - c.b, p.r - c.r, p.b, ks);
            if (c.r > 0 && c.b > 0)
               queue_blit(m.r - c.r, m.b - c.b, m.r, m.b,
                          p.r - c.r, p.b - c.b, p.r, p.b, kc);
            if (c.r > 0)
               queue_blit(m.r - c.r, m.t + c.t, m.r, m.b - c.b,
                          p.r - c.r, p.t + c.t, p.r, p.b - c.b, ks);
            // The center slice is always drawn, even when empty or inverted.
            queue_blit(m.l + c.l, m.t + c.t, m.r - c.r, m.b - c.b,
                       p.l + c.l, p.t + c.t, p.r - c.r, p.b - c.b, ks);
         end
         default: ;
      endcase
      // Flag the final command of this item.
      if (expected_cmds.size() > first) begin
         tail = expected_cmds.pop_back();
         tail.last_piece = 1'b1;
         expected_cmds.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------
   // Drivers and checker
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   // Offer one paint item, hold it until taken, then predict its commands.
   task automatic send_paint(input logic signed [CW-1:0] pl, input logic signed [CW-1:0] pt,
                             input logic signed [CW-1:0] pr, input logic signed [CW-1:0] pb,
                             input logic [7:0] ga);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_paint_left   <= pl;
      req_paint_top    <= pt;
      req_paint_right  <= pr;
      req_paint_bottom <= pb;
      req_global_alpha <= ga;
      do @(posedge clock); while (!req_ready);
      plan_blits(pl, pt, pr, pb, ga);
   endtask

   // Drop valid and wait until every owed command has come and the pipe is empty.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; call only while the block is idle.
   task automatic write_csr(input logic [1:0] index, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DRAW_MODE:     mode_q   = draw_mode_type'(data[1:0]);
         CSR_SOURCE_RECT:   source_q = data;
         CSR_CORNER_INSETS: insets_q = data;
         CSR_HAS_ALPHA:     alpha_q  = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(input draw_mode_type mode, input logic [63:0] src,
                              input logic [63:0] insets, input logic alpha);
      drain_results();
      write_csr(CSR_DRAW_MODE, 64'(mode));
      write_csr(CSR_SOURCE_RECT, src);
      write_csr(CSR_CORNER_INSETS, insets);
      write_csr(CSR_HAS_ALPHA, 64'(alpha));
   endtask

   // Inset for well-formed grids: mostly small positive, some zero, a few negative.
   function automatic int pick_inset();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0)
         return 0;
      if (sel == 1)
         return -int'($urandom_range(1, 10));
      return $urandom_range(1, 30);
   endfunction

   function automatic logic [7:0] pick_alpha();
      return ($urandom_range(1) == 0) ? FULL_ALPHA : 8'($urandom_range(255));
   endfunction

   // Paint rectangle of plausible size, now and then inverted.
   task automatic send_sane_paint();
      int l, t, w, h;
      l = int'($urandom_range(600)) - 300;
      t = int'($urandom_range(600)) - 300;
      w = $urandom_range(250);
      h = $urandom_range(250);
      if ($urandom_range(9) == 0)
         w = -w;
      send_paint(CW'(l), CW'(t), CW'(l + w), CW'(t + h), pick_alpha());
   endtask

   function automatic logic [63:0] pick_grid_source();
      int l, t;
      l = int'($urandom_range(200)) - 100;
      t = int'($urandom_range(200)) - 100;
      return pack_rect(l, t, l + int'($urandom_range(4, 120)), t + int'($urandom_range(4, 120)));
   endfunction

   // Hold-off: keep the receiver stalled, then release it.
   always begin : hold_off
      @(hold_off_go);
      holding = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      holding = 1'b0;
   end

   // Receiver: random stalls, always stalled during a hold-off, none while steady.
   always @(negedge clock) begin
      if (holding) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Compare each accepted command with the oldest one owed.
   always @(posedge clock) begin : check_blits
      blit_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch("command arrived with none expected");
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_src_left != want.src_left)
               report_mismatch($sformatf("src_left %0d, want %0d", rsp_src_left, want.src_left));
            if (rsp_src_top != want.src_top)
               report_mismatch($sformatf("src_top %0d, want %0d", rsp_src_top, want.src_top));
            if (rsp_src_right != want.src_right)
               report_mismatch($sformatf("src_right %0d, want %0d", rsp_src_right,
                                         want.src_right));
            if (rsp_src_bottom != want.src_bottom)
               report_mismatch($sformatf("src_bottom %0d, want %0d", rsp_src_bottom,
                                         want.src_bottom));
            if (rsp_dst_left != want.dst_left)
               report_mismatch($sformatf("dst_left %0d, want %0d", rsp_dst_left, want.dst_left));
            if (rsp_dst_top != want.dst_top)
               report_mismatch($sformatf("dst_top %0d, want %0d", rsp_dst_top, want.dst_top));
            if (rsp_dst_right != want.dst_right)
               report_mismatch($sformatf("dst_right %0d, want %0d", rsp_dst_right,
                                         want.dst_right));
            if (rsp_dst_bottom != want.dst_bottom)
               report_mismatch($sformatf("dst_bottom %0d, want %0d", rsp_dst_bottom,
                                         want.dst_bottom));
            if (rsp_blit_kind != want.kind)
               report_mismatch($sformatf("blit_kind %0d, want %0d", rsp_blit_kind, want.kind));
            if (rsp_last_piece != want.last_piece)
               report_mismatch($sformatf("last_piece %0b, want %0b", rsp_last_piece,
                                         want.last_piece));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers reset to mode none: the item must produce no command.
   task automatic test_reset_defaults();
      send_paint(16'sd0, 16'sd0, 16'sd10, 16'sd10, FULL_ALPHA);
   endtask

   // Hole mode: center and crop on each axis, odd halving, inverted paint.
   task automatic test_hole_mode();
      load_config(MODE_HOLE, pack_rect(10, 20, 50, 60), 64'd0, 1'b0);
      send_paint(16'sd0, 16'sd0, 16'sd101, 16'sd91, FULL_ALPHA);
      send_paint(16'sd5, 16'sd5, 16'sd20, 16'sd14, FULL_ALPHA);
      send_paint(16'sd0, 16'sd0, 16'sd40, 16'sd101, 8'd128);
      send_paint(16'sd100, 16'sd100, 16'sd0, 16'sd0, 8'd0);
   endtask

   // Stretch mode with full-range coordinates, then alpha off for a stretch copy.
   task automatic test_stretch_mode();
      load_config(MODE_STRETCH, pack_rect(-32768, -32768, 32767, 32767), 64'd0, 1'b1);
      send_paint(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, FULL_ALPHA);
      send_paint(16'sd0, 16'sd0, 16'sd1, 16'sd1, 8'd254);
      drain_results();
      write_csr(CSR_HAS_ALPHA, 64'd0);
      send_paint(16'sd3, 16'sd4, 16'sd500, 16'sd600, FULL_ALPHA);
   endtask

   // Grid mode: all nine slices, wrap, center only, negative and oversized insets.
   task automatic test_grid_mode();
      load_config(MODE_GRID, pack_rect(0, 0, 64, 48), pack_rect(8, 6, 10, 12), 1'b0);
      send_paint(16'sd100, 16'sd200, 16'sd300, 16'sd400, FULL_ALPHA);
      send_paint(16'sd0, 16'sd0, 16'sd20, 16'sd20, 8'd0);
      send_paint(16'sd32760, 16'sd32760, -16'sd32760, -16'sd32760, FULL_ALPHA);
      drain_results();
      write_csr(CSR_CORNER_INSETS, 64'd0);
      send_paint(16'sd10, 16'sd10, 16'sd50, 16'sd50, FULL_ALPHA);
      drain_results();
      write_csr(CSR_CORNER_INSETS, pack_rect(-5, 3, -2, 0));
      send_paint(16'sd10, 16'sd10, 16'sd50, 16'sd50, FULL_ALPHA);
      drain_results();
      // insets wider than the part: no top middle
      write_csr(CSR_CORNER_INSETS, pack_rect(40, 4, 30, 4));
      send_paint(-16'sd20, -16'sd20, 16'sd80, 16'sd80, FULL_ALPHA);
      load_config(MODE_GRID, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_paint(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, FULL_ALPHA);
      load_config(MODE_GRID, 64'd0, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0);
      send_paint(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, FULL_ALPHA);
      drain_results();
      write_csr(CSR_DRAW_MODE, 64'(MODE_NONE));
      send_paint(16'sd1, 16'sd2, 16'sd3, 16'sd4, 8'd7);
   endtask

   // Well-formed grids with random geometry and alpha, new registers every round.
   task automatic test_random_grid();
      for (int round = 0; round < 8; round++) begin
         load_config(MODE_GRID, pick_grid_source(),
                     pack_rect(pick_inset(), pick_inset(), pick_inset(), pick_inset()),
                     1'($urandom_range(1)));
         for (int n = 0; n < 22; n++)
            send_sane_paint();
      end
   endtask

   // Hold the receiver off so the block fills and stalls its input, run a
   // stretch with no idling, then pause the sender until all commands are in.
   task automatic test_backpressure();
      load_config(MODE_GRID, pack_rect(0, 0, 90, 70), pack_rect(7, 9, 11, 5), 1'b0);
      -> hold_off_go;
      for (int n = 0; n < 16; n++)
         send_sane_paint();
      steady = 1'b1;
      for (int n = 0; n < 30; n++)
         send_sane_paint();
      steady = 1'b0;
      drain_results();
      for (int n = 0; n < 6; n++)
         send_sane_paint();
   endtask

   // Any mode, full-range registers and fields.
   task automatic test_random_mixed();
      logic [63:0] insets;
      for (int round = 0; round < 6; round++) begin
         if ($urandom_range(1) == 0)
            insets = {$urandom, $urandom};
         else
            insets = pack_rect(pick_inset(), pick_inset(), pick_inset(), pick_inset());
         load_config(draw_mode_type'($urandom_range(3)), {$urandom, $urandom}, insets,
                     1'($urandom_range(1)));
         for (int n = 0; n < 22; n++)
            send_paint(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                       8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      errors           = 0;
      steady           = 1'b0;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = CSR_DRAW_MODE;
      csr_wdata        = 64'd0;
      req_valid        = 1'b0;
      req_paint_left   = '0;
      req_paint_top    = '0;
      req_paint_right  = '0;
      req_paint_bottom = '0;
      req_global_alpha = 8'd0;
      rsp_ready        = 1'b0;
      mode_q           = MODE_NONE;
      source_q         = 64'd0;
      insets_q         = 64'd0;
      alpha_q          = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_hole_mode();
      test_stretch_mode();
      test_grid_mode();
      test_random_grid();
      test_backpressure();
      test_random_mixed();

      drain_results();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(TIMEOUT_TIME);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
hdl/nsbp_pkg.sv
hdl/nsbp_geom.sv
hdl/nsbp_emit.sv
hdl/nine_slice_blit_planner.sv
test/nine_slice_blit_planner_tb.sv
